// File: sv/hsx_pkg.sv
// ----------------------------------------------------------------------------
// hsx_pkg
// shared types and constants of the five-point heat stencil core
// ----------------------------------------------------------------------------
package hsx_pkg;

  // temperatures are signed q16.16, coefficients unsigned q0.16
  localparam int unsigned TEMP_W  = 32;
  localparam int unsigned COEFF_W = 16;
  localparam int unsigned MASK_W  = 4;

  // config port geometry
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // arithmetic widths of the update datapath
  localparam int unsigned LAP_W  = TEMP_W + 2;        // w + e - 2t
  localparam int unsigned PROD_W = LAP_W + COEFF_W + 1; // signed product
  localparam int unsigned ACC_W  = PROD_W + 2;        // two products plus rounding
  localparam int unsigned SHR_W  = ACC_W - 16;        // after the q16 shift
  localparam int unsigned SUM_W  = SHR_W + 1;         // t added

  // edge mask bit positions
  localparam int unsigned MASK_LEFT   = 0;
  localparam int unsigned MASK_RIGHT  = 1;
  localparam int unsigned MASK_BOTTOM = 2;
  localparam int unsigned MASK_TOP    = 3;

  // register indexes, byte address is 4 times the index
  typedef enum logic [2:0] {
    REG_COEFF_X      = 3'd0,
    REG_COEFF_Y      = 3'd1,
    REG_DIRICHLET    = 3'd2,
    REG_LEFT_VALUE   = 3'd3,
    REG_RIGHT_VALUE  = 3'd4,
    REG_BOTTOM_VALUE = 3'd5,
    REG_TOP_VALUE    = 3'd6
  } cfg_reg_e;

  localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd4096;

  typedef struct packed {
    logic [COEFF_W-1:0] coeff_x;
    logic [COEFF_W-1:0] coeff_y;
    logic [MASK_W-1:0]  dirichlet_mask;
    logic [TEMP_W-1:0]  left_value;
    logic [TEMP_W-1:0]  right_value;
    logic [TEMP_W-1:0]  bottom_value;
    logic [TEMP_W-1:0]  top_value;
  } cfg_t;

endpackage

// File: sv/hsx_ram.sv
// ----------------------------------------------------------------------------
// hsx_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module hsx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1026
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/hsx_cfg.sv
// ----------------------------------------------------------------------------
// hsx_cfg
// apb register file: coefficients, edge mask and fixed edge temperatures
// ----------------------------------------------------------------------------
module hsx_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hsx_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [hsx_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [hsx_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output hsx_pkg::cfg_t                    cfg_o
);

  import hsx_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = cfg_reg_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_COEFF_X:      cfg_d.coeff_x        = pwdata[COEFF_W-1:0];
        REG_COEFF_Y:      cfg_d.coeff_y        = pwdata[COEFF_W-1:0];
        REG_DIRICHLET:    cfg_d.dirichlet_mask = pwdata[MASK_W-1:0];
        REG_LEFT_VALUE:   cfg_d.left_value     = pwdata[TEMP_W-1:0];
        REG_RIGHT_VALUE:  cfg_d.right_value    = pwdata[TEMP_W-1:0];
        REG_BOTTOM_VALUE: cfg_d.bottom_value   = pwdata[TEMP_W-1:0];
        REG_TOP_VALUE:    cfg_d.top_value      = pwdata[TEMP_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coeff_x        <= COEFF_RESET;
      cfg_q.coeff_y        <= COEFF_RESET;
      cfg_q.dirichlet_mask <= '0;
      cfg_q.left_value     <= '0;
      cfg_q.right_value    <= '0;
      cfg_q.bottom_value   <= '0;
      cfg_q.top_value      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_COEFF_X:      prdata = APB_DATA_W'(cfg_q.coeff_x);
      REG_COEFF_Y:      prdata = APB_DATA_W'(cfg_q.coeff_y);
      REG_DIRICHLET:    prdata = APB_DATA_W'(cfg_q.dirichlet_mask);
      REG_LEFT_VALUE:   prdata = cfg_q.left_value;
      REG_RIGHT_VALUE:  prdata = cfg_q.right_value;
      REG_BOTTOM_VALUE: prdata = cfg_q.bottom_value;
      REG_TOP_VALUE:    prdata = cfg_q.top_value;
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/heat_stencil_explicit_step_core.sv
// ----------------------------------------------------------------------------
// heat_stencil_explicit_step_core
// one explicit ftcs time step of the 2d heat equation over a raster tile
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | sink      | in_valid_i/in_stall_o  | cell_temperature_i, row_end_i, final_row_i
//  out     | source    | out_valid_o/out_stall_i| new_temperature_o, row_last_o, frame_last_o
//  apb     | slave     | psel/penable/pready    | paddr, pwdata, prdata (7 regs, 4 bytes apart)
//
//  one request per cycle sustained while out_stall_i stays low; a result leaves
//  through s1 (line-buffer read), s2 (products) and the output register
//  line buffers are two single-port-read rams, read at accept, a register ahead of the math
//  reset clears counters, window and config; the line buffers start undefined
//  and need no clearing pass, every column read for a result is written first
//  a stall on the output holds the stages back one by one; in_stall_o rises
//  only once the input register cannot drain
//
module heat_stencil_explicit_step_core #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input requests
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [hsx_pkg::TEMP_W-1:0] cell_temperature_i,
  input  logic                           row_end_i,
  input  logic                           final_row_i,
  // result requests
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [hsx_pkg::TEMP_W-1:0] new_temperature_o,
  output logic                           row_last_o,
  output logic                           frame_last_o,
  // config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hsx_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hsx_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hsx_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  import hsx_pkg::*;

  // line holds the tile row plus both halo cells
  localparam int unsigned LINE_DEPTH = MAX_WIDTH + 2;
  localparam int unsigned AW         = $clog2(LINE_DEPTH);
  localparam int unsigned CW         = $clog2(LINE_DEPTH + 1);
  localparam logic [CW-1:0] LineEnd  = CW'(LINE_DEPTH);
  localparam logic [CW-1:0] ColTwo   = CW'(2);

  localparam logic signed [SUM_W-1:0] SatMax = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SatMin = -SUM_W'(64'sd2147483648);
  localparam logic signed [ACC_W-1:0] RoundHalf = ACC_W'(32768);

  cfg_t cfg;

  hsx_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // --------------------------------------------------------------------------
  // flow control
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_res_q;
  logic out_free, s2_free, s2_move, s1_move, in_acc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_move    = s2_valid_q && out_free;
  assign s2_free    = !s2_valid_q || out_free;
  // requests that give no result leave s1 without needing s2
  assign s1_move    = s1_valid_q && (!s1_res_q || s2_free);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_acc     = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // tile position, advanced at accept so the ram read can start at once
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_q, col_d;
  logic [1:0]    row_q, row_d;
  logic          bot_q, bot_d;
  logic          stored;

  assign stored = col_q < LineEnd;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    bot_d = bot_q;
    if (row_end_i) begin
      col_d = '0;
      if (final_row_i) begin
        row_d = '0;
        bot_d = 1'b1;
      end else if (row_q == 2'd2) begin
        bot_d = 1'b0;
      end else begin
        row_d = row_q + 2'd1;
      end
    end else if (stored) begin
      col_d = col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      bot_q <= 1'b1;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
      bot_q <= bot_d;
    end
  end

  // --------------------------------------------------------------------------
  // line buffers
  // --------------------------------------------------------------------------
  logic [TEMP_W-1:0] up_rdata, mid_rdata;
  logic              buf_we;
  logic [CW-1:0]     s1_col_q;
  logic [TEMP_W-1:0] s1_cell_q;
  logic [TEMP_W-1:0] s1_up, s1_mid;
  logic              s1_stored_q;

  assign buf_we = s1_move && s1_stored_q;

  hsx_ram #(.WIDTH(TEMP_W), .DEPTH(LINE_DEPTH)) u_upper_line (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (s1_col_q[AW-1:0]),
    .wdata_i (s1_mid),
    .re_i    (in_acc),
    .raddr_i (col_q[AW-1:0]),
    .rdata_o (up_rdata)
  );

  hsx_ram #(.WIDTH(TEMP_W), .DEPTH(LINE_DEPTH)) u_middle_line (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (s1_col_q[AW-1:0]),
    .wdata_i (s1_cell_q),
    .re_i    (in_acc),
    .raddr_i (col_q[AW-1:0]),
    .rdata_o (mid_rdata)
  );

  // --------------------------------------------------------------------------
  // s1: accepted request with its line-buffer read in flight
  // --------------------------------------------------------------------------
  logic              s1_rend_q, s1_fin_q, s1_bot_q;
  logic              byp_q, byp_d;
  logic [TEMP_W-1:0] byp_up_q, byp_mid_q;

  // a one-cell row rereads the column written in the same cycle
  assign byp_d = buf_we && stored && (s1_col_q == col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (in_acc) begin
      byp_q <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cell_q   <= cell_temperature_i;
      s1_rend_q   <= row_end_i;
      s1_fin_q    <= final_row_i;
      s1_col_q    <= col_q;
      s1_bot_q    <= bot_q;
      s1_stored_q <= stored;
      s1_res_q    <= (row_q == 2'd2) && (col_q >= ColTwo);
      byp_up_q    <= s1_mid;
      byp_mid_q   <= s1_cell_q;
    end
  end

  // overlong rows read as zero past the buffer end
  assign s1_up  = !s1_stored_q ? '0 : (byp_q ? byp_up_q  : up_rdata);
  assign s1_mid = !s1_stored_q ? '0 : (byp_q ? byp_mid_q : mid_rdata);

  // 3x3 window columns: n/t/s at column c-1, w at column c-2 middle row
  logic signed [TEMP_W-1:0] win_n_q, win_t_q, win_s_q, win_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_n_q <= '0;
      win_t_q <= '0;
      win_s_q <= '0;
      win_w_q <= '0;
    end else if (s1_move) begin
      win_w_q <= win_t_q;
      win_n_q <= s1_up;
      win_t_q <= s1_mid;
      win_s_q <= s1_cell_q;
    end
  end

  // laplacian terms, exact
  logic signed [LAP_W-1:0]  lap_x, lap_y;
  logic signed [PROD_W-1:0] prod_x, prod_y;

  assign lap_x = LAP_W'(win_w_q) + LAP_W'($signed(s1_mid)) - (LAP_W'(win_t_q) <<< 1);
  assign lap_y = LAP_W'(win_s_q) + LAP_W'(win_n_q) - (LAP_W'(win_t_q) <<< 1);
  assign prod_x = PROD_W'($signed({1'b0, cfg.coeff_x})) * PROD_W'(lap_x);
  assign prod_y = PROD_W'($signed({1'b0, cfg.coeff_y})) * PROD_W'(lap_y);

  // fixed edges, later ones win: left, right, bottom, top
  logic              ovr_hit;
  logic [TEMP_W-1:0] ovr_val;

  always_comb begin
    ovr_hit = 1'b0;
    ovr_val = cfg.left_value;
    if (cfg.dirichlet_mask[MASK_LEFT] && (s1_col_q == ColTwo)) begin
      ovr_hit = 1'b1;
      ovr_val = cfg.left_value;
    end
    if (cfg.dirichlet_mask[MASK_RIGHT] && s1_rend_q) begin
      ovr_hit = 1'b1;
      ovr_val = cfg.right_value;
    end
    if (cfg.dirichlet_mask[MASK_BOTTOM] && s1_bot_q) begin
      ovr_hit = 1'b1;
      ovr_val = cfg.bottom_value;
    end
    if (cfg.dirichlet_mask[MASK_TOP] && s1_fin_q) begin
      ovr_hit = 1'b1;
      ovr_val = cfg.top_value;
    end
  end

  // --------------------------------------------------------------------------
  // s2: registered products
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] s2_px_q, s2_py_q;
  logic signed [TEMP_W-1:0] s2_t_q;
  logic                     s2_ovr_q, s2_rlast_q, s2_flast_q;
  logic [TEMP_W-1:0]        s2_ovr_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_move && s1_res_q) begin
      s2_valid_q <= 1'b1;
    end else if (s2_move) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_res_q) begin
      s2_px_q      <= prod_x;
      s2_py_q      <= prod_y;
      s2_t_q       <= win_t_q;
      s2_ovr_q     <= ovr_hit;
      s2_ovr_val_q <= ovr_val;
      s2_rlast_q   <= s1_rend_q;
      s2_flast_q   <= s1_rend_q && s1_fin_q;
    end
  end

  // round to nearest, ties up, then add t and saturate
  logic signed [ACC_W-1:0] acc;
  logic signed [SHR_W-1:0] acc_shr;
  logic signed [SUM_W-1:0] upd;
  logic [TEMP_W-1:0]       upd_sat;

  assign acc     = ACC_W'(s2_px_q) + ACC_W'(s2_py_q) + RoundHalf;
  assign acc_shr = acc[ACC_W-1:16];
  assign upd     = SUM_W'(s2_t_q) + SUM_W'(acc_shr);

  always_comb begin
    if (upd > SatMax) begin
      upd_sat = SatMax[TEMP_W-1:0];
    end else if (upd < SatMin) begin
      upd_sat = SatMin[TEMP_W-1:0];
    end else begin
      upd_sat = upd[TEMP_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic [TEMP_W-1:0] out_temp_q;
  logic              out_rlast_q, out_flast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      out_temp_q  <= s2_ovr_q ? s2_ovr_val_q : upd_sat;
      out_rlast_q <= s2_rlast_q;
      out_flast_q <= s2_flast_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign new_temperature_o = out_temp_q;
  assign row_last_o        = out_rlast_q;
  assign frame_last_o      = out_flast_q;

`ifndef NO_ASSERTIONS
  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= LineEnd)
    else $error("column index past line end");

  a_row_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q != 2'd3)
    else $error("row index past saturation");

  a_bypass_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_q && s1_valid_q |-> s1_stored_q)
    else $error("bypass on an unstored column");

  a_frame_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> row_last_o)
    else $error("frame end without row end");

  a_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !out_free |=> s2_valid_q)
    else $error("stage two result lost under stall");
`endif

endmodule
